/* rtl/core/ssbt_pkg.sv */
// Shared constants, codes and types for the swap segment block translator.
package ssbt_pkg;

    localparam int MAP_ENTRIES = 64;
    localparam int ADDR_BITS   = 24;
    localparam int IDX_W       = $clog2(MAP_ENTRIES);
    localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);
    localparam int INDEX_W     = 6;
    localparam int CHUNK_W     = 21;
    localparam int BLK_W       = CHUNK_W + 1;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 48;

    localparam logic [CHUNK_W-1:0]   MIN_CHUNK_RST      = CHUNK_W'(32);
    localparam logic [CHUNK_W-1:0]   MAX_CHUNK_RST      = CHUNK_W'(1024);
    localparam logic [ADDR_BITS-1:0] SWAP_BLOCKS_RST    = '1;
    localparam logic [ADDR_BITS-1:0] SEGMENT_BLOCKS_RST = '0;

    typedef enum logic {
        OP_WRITE     = 1'b0,
        OP_TRANSLATE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_BEYOND_SEG   = 2'd1,
        STATUS_BEYOND_SWAP  = 2'd2,
        STATUS_BEYOND_TABLE = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_CHUNK      = 2'd0,
        REG_MAX_CHUNK      = 2'd1,
        REG_SWAP_BLOCKS    = 2'd2,
        REG_SEGMENT_BLOCKS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic done;
        logic beyond_table;
    } walk_status_t;

endpackage

/* rtl/core/ssbt_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module ssbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/ssbt_walk.sv */
// Chunk walker: one shared subtract and compare steps through one chunk per cycle.
module ssbt_walk import ssbt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ADDR_BITS-1:0] start_off,
    input  logic [CHUNK_W-1:0]   min_chunk,
    input  logic [CHUNK_W-1:0]   max_chunk,
    output walk_status_t         stat,
    output logic [IDX_W-1:0]     idx,
    output logic [ADDR_BITS-1:0] off_rem,
    output logic [BLK_W-1:0]     blk
);

    logic                 busy_reg, busy_next;
    logic [ADDR_BITS-1:0] off_reg, off_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [ADDR_BITS:0]   diff;
    logic                 ge;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 at_end;

    always_comb
    begin
        diff    = {1'b0, off_reg} - (ADDR_BITS + 1)'(blk_reg);
        ge      = ~diff[ADDR_BITS];
        cnt_inc = cnt_reg + 1'b1;
        at_end  = (cnt_inc == CNT_W'(MAP_ENTRIES));

        stat.done         = busy_reg && (!ge || at_end);
        stat.beyond_table = busy_reg && ge && at_end;

        busy_next = busy_reg;
        off_next  = off_reg;
        blk_next  = blk_reg;
        cnt_next  = cnt_reg;

        if (start)
        begin
            busy_next = 1'b1;
            off_next  = start_off;
            // A zero minimum chunk counts as one block.
            blk_next  = (min_chunk == '0) ? BLK_W'(1) : BLK_W'(min_chunk);
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                off_next = diff[ADDR_BITS-1:0];
                if (blk_reg < BLK_W'(max_chunk))
                begin
                    blk_next = {blk_reg[BLK_W-2:0], 1'b0};
                end
                cnt_next = cnt_inc;
            end
            if (!ge || at_end)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            off_reg  <= '0;
            blk_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            off_reg  <= off_next;
            blk_reg  <= blk_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign idx     = cnt_reg[IDX_W-1:0];
    assign off_rem = off_reg;
    assign blk     = blk_reg;

endmodule

/* rtl/core/swap_segment_block_translate.sv */
// Top level of the swap segment block translator: sequencer, checks and result path.
//
// Input words arrive on the s_ group. s_tuser selects the operation: a write
// word loads one chunk table entry, a translate word maps virt_offset and
// length onto the first contiguous disk run. Every input word yields exactly
// one output word on the m_ group: disk_base and run_length in m_tdata and
// the status code in m_tuser. Any error status comes with zero data fields.
// Configuration registers are written through cfg_wr_en, cfg_addr and
// cfg_wdata, one register per cycle, and should only change while idle.
//
// One word is in work at a time; s_tready is high only while the sequencer
// is idle. A write word or a segment overflow goes from S_WRITE or S_SEG to
// S_DONE, which hands its result to the output register. A translate word
// goes through S_SEG, S_WALK, S_RUN, S_POS and S_FIN to S_DONE; in S_WALK
// the walker's single subtract and compare unit steps over at most 63 chunks,
// one chunk per cycle. A walk past the last table entry goes from S_WALK
// straight to S_DONE. The result sits in an output register,
// so a stalled receiver does not block the next input word; only that word's
// result waits until the register is free. Reset idles the sequencer, drops
// m_tvalid and loads the configuration reset values; the table is not cleared.
module swap_segment_block_translate import ssbt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata from bit 0: entry_index[5:0], entry_base[29:6], virt_offset[53:30],
    // length[77:54], reverse[78], zero fill[79].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: operation[0].
    input  logic                 s_tuser,
    // Output stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata from bit 0: disk_base[23:0], run_length[47:24].
    output logic [M_TDATA_W-1:0] m_tdata,
    // tuser: status[1:0].
    output logic [1:0]           m_tuser,
    // Configuration write port.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SEG,
        S_WALK,
        S_RUN,
        S_POS,
        S_FIN,
        S_DONE
    } fsm_t;

    // Configuration registers.
    logic [CHUNK_W-1:0]   min_chunk_reg;
    logic [CHUNK_W-1:0]   max_chunk_reg;
    logic [ADDR_BITS-1:0] swap_blocks_reg;
    logic [ADDR_BITS-1:0] segment_blocks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_chunk_reg      <= MIN_CHUNK_RST;
            max_chunk_reg      <= MAX_CHUNK_RST;
            swap_blocks_reg    <= SWAP_BLOCKS_RST;
            segment_blocks_reg <= SEGMENT_BLOCKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_MIN_CHUNK:      min_chunk_reg      <= cfg_wdata[CHUNK_W-1:0];
                REG_MAX_CHUNK:      max_chunk_reg      <= cfg_wdata[CHUNK_W-1:0];
                REG_SWAP_BLOCKS:    swap_blocks_reg    <= cfg_wdata[ADDR_BITS-1:0];
                REG_SEGMENT_BLOCKS: segment_blocks_reg <= cfg_wdata[ADDR_BITS-1:0];
            endcase
        end
    end

    // Sequencer state and data path registers.
    fsm_t                 state_reg, state_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [ADDR_BITS-1:0] base_in_reg, base_in_next;
    logic [ADDR_BITS-1:0] off_reg, off_next;
    logic [ADDR_BITS-1:0] len_reg, len_next;
    logic                 rev_reg, rev_next;
    logic [ADDR_BITS-1:0] entry_reg, entry_next;
    logic [BLK_W-1:0]     room_reg, room_next;
    logic [ADDR_BITS-1:0] run_reg, run_next;
    logic [BLK_W-1:0]     pos_reg, pos_next;
    logic                 swap_err_reg, swap_err_next;
    logic [ADDR_BITS-1:0] res_base_reg, res_base_next;
    logic [ADDR_BITS-1:0] res_run_reg, res_run_next;
    status_t              res_status_reg, res_status_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ADDR_BITS-1:0] m_base_reg, m_base_next;
    logic [ADDR_BITS-1:0] m_run_reg, m_run_next;
    status_t              m_status_reg, m_status_next;

    // Walker and table interface.
    logic                 walk_start;
    walk_status_t         walk_stat;
    logic [IDX_W-1:0]     walk_idx;
    logic [ADDR_BITS-1:0] walk_off;
    logic [BLK_W-1:0]     walk_blk;
    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_BITS-1:0] ram_rdata;

    // Arithmetic used by single states.
    logic                 s_accept;
    logic                 out_free;
    logic [ADDR_BITS:0]   seg_sum;
    logic [ADDR_BITS:0]   swap_sum;
    logic [BLK_W-1:0]     room_calc;
    logic [ADDR_BITS-1:0] sum_base;

    ssbt_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (walk_start),
        .start_off (off_reg),
        .min_chunk (min_chunk_reg),
        .max_chunk (max_chunk_reg),
        .stat      (walk_stat),
        .idx       (walk_idx),
        .off_rem   (walk_off),
        .blk       (walk_blk)
    );

    ssbt_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (MAP_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(index_reg)),
        .wdata (base_in_reg),
        .re    (ram_re),
        .raddr (walk_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s_accept = s_tvalid && s_tready;
        out_free = !m_tvalid_reg || m_tready;

        // Segment bound check: offset plus length against the segment size.
        seg_sum   = {1'b0, off_reg} + {1'b0, len_reg};
        // Swap device check: chunk base plus chunk size against the device size.
        swap_sum  = {1'b0, ram_rdata} + (ADDR_BITS + 1)'(walk_blk);
        // The offset left after the walk is below the chunk size, so it fits BLK_W.
        room_calc = walk_blk - walk_off[BLK_W-1:0];
        sum_base  = entry_reg + ADDR_BITS'(pos_reg);

        state_next      = state_reg;
        index_next      = index_reg;
        base_in_next    = base_in_reg;
        off_next        = off_reg;
        len_next        = len_reg;
        rev_next        = rev_reg;
        entry_next      = entry_reg;
        room_next       = room_reg;
        run_next        = run_reg;
        pos_next        = pos_reg;
        swap_err_next   = swap_err_reg;
        res_base_next   = res_base_reg;
        res_run_next    = res_run_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_base_next     = m_base_reg;
        m_run_next      = m_run_reg;
        m_status_next   = m_status_reg;

        walk_start = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    index_next   = s_tdata[5:0];
                    base_in_next = s_tdata[29:6];
                    off_next     = s_tdata[53:30];
                    len_next     = s_tdata[77:54];
                    rev_next     = s_tdata[78];
                    state_next   = (op_t'(s_tuser) == OP_WRITE) ? S_WRITE : S_SEG;
                end
            end

            S_WRITE:
            begin
                res_base_next = '0;
                res_run_next  = '0;
                if (32'(index_reg) >= MAP_ENTRIES)
                begin
                    res_status_next = STATUS_BEYOND_TABLE;
                end
                else
                begin
                    ram_we          = 1'b1;
                    res_status_next = STATUS_OK;
                end
                state_next = S_DONE;
            end

            S_SEG:
            begin
                if (seg_sum > {1'b0, segment_blocks_reg})
                begin
                    res_base_next   = '0;
                    res_run_next    = '0;
                    res_status_next = STATUS_BEYOND_SEG;
                    state_next      = S_DONE;
                end
                else
                begin
                    walk_start = 1'b1;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (walk_stat.done)
                begin
                    if (walk_stat.beyond_table)
                    begin
                        res_base_next   = '0;
                        res_run_next    = '0;
                        res_status_next = STATUS_BEYOND_TABLE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_RUN;
                    end
                end
            end

            S_RUN:
            begin
                entry_next    = ram_rdata;
                swap_err_next = (swap_sum > {1'b0, swap_blocks_reg});
                room_next     = room_calc;
                run_next      = (len_reg < ADDR_BITS'(room_calc)) ? len_reg
                                                                  : ADDR_BITS'(room_calc);
                state_next    = S_POS;
            end

            S_POS:
            begin
                // Reverse places the run so that it ends at the chunk size minus the remaining offset.
                pos_next   = rev_reg ? (room_reg - BLK_W'(run_reg)) : walk_off[BLK_W-1:0];
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (swap_err_reg)
                begin
                    res_base_next   = '0;
                    res_run_next    = '0;
                    res_status_next = STATUS_BEYOND_SWAP;
                end
                else
                begin
                    res_base_next   = sum_base;
                    res_run_next    = run_reg;
                    res_status_next = STATUS_OK;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_base_next   = res_base_reg;
                    m_run_next    = res_run_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            index_reg      <= '0;
            base_in_reg    <= '0;
            off_reg        <= '0;
            len_reg        <= '0;
            rev_reg        <= 1'b0;
            entry_reg      <= '0;
            room_reg       <= '0;
            run_reg        <= '0;
            pos_reg        <= '0;
            swap_err_reg   <= 1'b0;
            res_base_reg   <= '0;
            res_run_reg    <= '0;
            res_status_reg <= STATUS_OK;
            m_tvalid_reg   <= 1'b0;
            m_base_reg     <= '0;
            m_run_reg      <= '0;
            m_status_reg   <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            index_reg      <= index_next;
            base_in_reg    <= base_in_next;
            off_reg        <= off_next;
            len_reg        <= len_next;
            rev_reg        <= rev_next;
            entry_reg      <= entry_next;
            room_reg       <= room_next;
            run_reg        <= run_next;
            pos_reg        <= pos_next;
            swap_err_reg   <= swap_err_next;
            res_base_reg   <= res_base_next;
            res_run_reg    <= res_run_next;
            res_status_reg <= res_status_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_base_reg     <= m_base_next;
            m_run_reg      <= m_run_next;
            m_status_reg   <= m_status_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_run_reg, m_base_reg};
    assign m_tuser  = m_status_reg;

endmodule

/* rtl/core/ssbt_checker.sv */
// Port level checks for the swap segment block translator, bound to the top level.
module ssbt_checker import ssbt_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    // The block works on one word at a time: it stops taking input right after a word.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is still in work");

    // Every error status carries zero data fields.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata == '0))
        else $error("error result with nonzero data fields");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

endmodule

bind swap_segment_block_translate ssbt_checker u_ssbt_checker (.*);
